// File: src/keypad_debounce_long_press_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keypad scanner and debouncer
// Shared helpers for concurrent checks, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define KEYPAD_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// Check a property at every rising edge outside reset.
`define KDLP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define KDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// Keypad debounce package
// Key codes, register indexes, reset values and the keypad layout decode.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    typedef logic [6:0]  key_t;
    typedef logic [31:0] msec_t;
    typedef logic [11:0] matrix_t;
    typedef logic [1:0]  cfg_addr_t;

    localparam key_t KEY_NONE = 7'h00;
    localparam key_t KEY_STAR = 7'h2A;  // '*'
    localparam key_t KEY_LONG = 7'h52;  // 'R'
    localparam key_t KEY_HASH = 7'h23;  // '#'
    localparam key_t KEY_ZERO = 7'h30;  // '0'
    localparam key_t KEY_ONE  = 7'h31;  // '1'

    localparam cfg_addr_t CFG_SCAN_PERIOD = 2'd0;
    localparam cfg_addr_t CFG_DEBOUNCE    = 2'd1;
    localparam cfg_addr_t CFG_LONG_PRESS  = 2'd2;

    localparam logic [7:0]  SCAN_PERIOD_RST = 8'd5;
    localparam logic [15:0] DEBOUNCE_RST    = 16'd30;
    localparam logic [15:0] LONG_PRESS_RST  = 16'd2000;

    typedef struct packed {
        logic [7:0]  scan_period;
        logic [15:0] debounce;
        logic [15:0] long_press;
    } cfg_t;

    // Phone layout in row-major order: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
    function automatic key_t layout_key(input logic [3:0] pos);
        key_t k;
        begin
            unique case (pos)
                4'd9:    k = KEY_STAR;
                4'd10:   k = KEY_ZERO;
                4'd11:   k = KEY_HASH;
                4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8:
                         k = key_t'(KEY_ONE + key_t'(pos));
                default: k = KEY_NONE;
            endcase
            return k;
        end
    endfunction

    // First pressed key in row-major order, or no key.
    function automatic key_t decode_matrix(input matrix_t bits);
        key_t k;
        begin
            k = KEY_NONE;
            for (int i = 11; i >= 0; i--) begin
                if (bits[i]) begin
                    k = layout_key(4'(i));
                end
            end
            return k;
        end
    endfunction

endpackage

// File: src/keypad_debounce_long_press.sv
// ----------------------------------------------------------------------------
// Keypad scanner debouncer with star long press
// Debounces 4x3 keypad samples and reports key presses as ASCII events.
// ----------------------------------------------------------------------------
//  Channel   Ports              Payload
//  s_        tvalid/tready      tdata: time_now[31:0], key_matrix[43:32]
//  m_        tvalid/tready      tdata: key_event[6:0]
//  cfg_      wr_en/addr         wr_data: scan period, debounce, long press
//
//  One result per sample; one sample per cycle sustained while m_ is not stalled.
//  A sample passes the input register, then the state update and the
//  result register, all in one pass of compare and subtract logic.
//  The sample register frees whenever the result register is empty or taken.
//  Reset clears all key and timing state and loads the default settings.
// ----------------------------------------------------------------------------
`include "keypad_debounce_long_press_defines.svh"

module keypad_debounce_long_press (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,      // [31:0] time_now, [43:32] key_matrix
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [6:0] key_event
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data
);

    logic              in_vld_reg;
    kdlp_pkg::msec_t   in_time_reg;
    kdlp_pkg::matrix_t in_keys_reg;
    logic              out_vld_reg;
    kdlp_pkg::key_t    out_key_reg;
    kdlp_pkg::cfg_t    cfg_reg;
    kdlp_pkg::key_t    key_event;
    logic              s_xfer;
    logic              step;

    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_key_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_period <= kdlp_pkg::SCAN_PERIOD_RST;
            cfg_reg.debounce    <= kdlp_pkg::DEBOUNCE_RST;
            cfg_reg.long_press  <= kdlp_pkg::LONG_PRESS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                kdlp_pkg::CFG_SCAN_PERIOD: cfg_reg.scan_period <= cfg_wr_data[7:0];
                kdlp_pkg::CFG_DEBOUNCE:    cfg_reg.debounce    <= cfg_wr_data;
                kdlp_pkg::CFG_LONG_PRESS:  cfg_reg.long_press  <= cfg_wr_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Sample register: load on transfer, drop once processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_xfer) begin
            in_vld_reg <= 1'b1;
        end else if (step) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_time_reg <= s_tdata[31:0];
            in_keys_reg <= s_tdata[43:32];
        end
    end

    kdlp_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step),
        .time_now   (in_time_reg),
        .key_matrix (in_keys_reg),
        .cfg        (cfg_reg),
        .key_event  (key_event)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_key_reg <= key_event;
        end
    end

    `KDLP_ASSERT_NEXT(a_xfer_loads_sample, aclk, aresetn, s_xfer, in_vld_reg,
        "accepted sample not held")
    `KDLP_ASSERT(a_step_needs_room, aclk, aresetn,
        !step || !out_vld_reg || m_tready,
        "sample processed while result register is blocked")
    `KDLP_ASSERT_NEXT(a_step_makes_result, aclk, aresetn, step, out_vld_reg,
        "processed sample gave no result")

endmodule

// File: src/kdlp_engine.sv
// ----------------------------------------------------------------------------
// Keypad debounce engine
// Holds the scan, debounce and long-press state and works out the event
// for one keypad sample in combinational logic.
// ----------------------------------------------------------------------------
`include "keypad_debounce_long_press_defines.svh"

module kdlp_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  kdlp_pkg::msec_t  time_now,
    input  kdlp_pkg::matrix_t key_matrix,
    input  kdlp_pkg::cfg_t   cfg,
    output kdlp_pkg::key_t   key_event
);

    kdlp_pkg::msec_t last_scan_reg, last_scan_next;
    kdlp_pkg::msec_t change_time_reg, change_time_next;
    kdlp_pkg::msec_t press_start_reg, press_start_next;
    kdlp_pkg::key_t  candidate_reg, candidate_next;
    kdlp_pkg::key_t  stable_reg, stable_next;
    logic            long_done_reg, long_done_next;

    kdlp_pkg::key_t  key;
    logic            scan_ok;
    logic            reported;

    assign key     = kdlp_pkg::decode_matrix(key_matrix);
    assign scan_ok = (time_now - last_scan_reg) >= {24'd0, cfg.scan_period};

    always_comb begin
        last_scan_next   = last_scan_reg;
        change_time_next = change_time_reg;
        press_start_next = press_start_reg;
        candidate_next   = candidate_reg;
        stable_next      = stable_reg;
        long_done_next   = long_done_reg;
        key_event        = kdlp_pkg::KEY_NONE;
        reported         = 1'b0;
        if (step_en && scan_ok) begin
            last_scan_next = time_now;
            candidate_next = key;
            if (key != candidate_reg) begin
                change_time_next = time_now;
            end
            if (((time_now - change_time_next) >= {16'd0, cfg.debounce}) &&
                (stable_reg != key)) begin
                stable_next = key;
                if (key != kdlp_pkg::KEY_NONE) begin
                    press_start_next = time_now;
                    long_done_next   = 1'b0;
                    if (key != kdlp_pkg::KEY_STAR) begin
                        key_event = key;
                        reported  = 1'b1;
                    end
                end else if ((stable_reg == kdlp_pkg::KEY_STAR) && !long_done_reg) begin
                    // short star press, report on release
                    key_event = kdlp_pkg::KEY_STAR;
                    reported  = 1'b1;
                end
            end
            if (!reported && (stable_next == kdlp_pkg::KEY_STAR) && !long_done_next &&
                ((time_now - press_start_next) >= {16'd0, cfg.long_press})) begin
                long_done_next = 1'b1;
                key_event      = kdlp_pkg::KEY_LONG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_scan_reg   <= '0;
            change_time_reg <= '0;
            press_start_reg <= '0;
            candidate_reg   <= kdlp_pkg::KEY_NONE;
            stable_reg      <= kdlp_pkg::KEY_NONE;
            long_done_reg   <= 1'b0;
        end else begin
            last_scan_reg   <= last_scan_next;
            change_time_reg <= change_time_next;
            press_start_reg <= press_start_next;
            candidate_reg   <= candidate_next;
            stable_reg      <= stable_next;
            long_done_reg   <= long_done_next;
        end
    end

    `KDLP_ASSERT_NEXT(a_idle_holds_state, aclk, aresetn, !step_en,
        $stable(stable_reg) && $stable(last_scan_reg) && $stable(long_done_reg),
        "state changed without a sample")
    `KDLP_ASSERT_NEXT(a_long_marks_done, aclk, aresetn,
        step_en && (key_event == kdlp_pkg::KEY_LONG),
        long_done_reg && (stable_reg == kdlp_pkg::KEY_STAR),
        "long press sent without marking star hold done")
    `KDLP_ASSERT_NEXT(a_event_has_cause, aclk, aresetn,
        step_en && (key_event != kdlp_pkg::KEY_NONE),
        (stable_reg != $past(stable_reg)) || (long_done_reg && !$past(long_done_reg)),
        "key event without a stable key change or long press")

endmodule

// File: test/keypad_event_checker.sv
// ----------------------------------------------------------------------------
// Keypad event checker
// Watches the sample and event streams and the register port, predicts the
// key event of every accepted sample and compares it with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keypad_event_checker
    import kdlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,      // [31:0] time_now, [43:32] key_matrix
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,      // [6:0] key_event
    input  logic        cfg_wr_en,
    input  cfg_addr_t   cfg_addr,
    input  logic [15:0] cfg_wr_data,
    output int          n_fail,
    output int          n_results,
    output int          n_due,
    output int          n_events,
    output int          n_long
);

    // Settings as last written
    logic [7:0]  scan_period;
    logic [15:0] debounce_time;
    logic [15:0] long_time;

    // Debouncer state
    msec_t prev_scan_ms;
    msec_t cand_since_ms;
    msec_t held_since_ms;
    key_t  cand_key;
    key_t  steady_key;
    logic  long_sent;

    key_t  events_due[$];

    function automatic key_t first_pressed(input matrix_t bits);
        key_t k;
        logic found;
        k = KEY_NONE;
        found = 1'b0;
        for (int i = 0; i < 12; i++) begin
            if (bits[i] && !found) begin
                found = 1'b1;
                if (i == 9)       k = KEY_STAR;
                else if (i == 10) k = KEY_ZERO;
                else if (i == 11) k = KEY_HASH;
                else              k = KEY_ONE + key_t'(i);
            end
        end
        return k;
    endfunction

    function automatic key_t scan_sample(input msec_t now, input matrix_t bits);
        key_t k;
        key_t prev;
        msec_t since;
        since = now - prev_scan_ms;
        if (since < msec_t'(scan_period))
            return KEY_NONE;
        prev_scan_ms = now;

        k = first_pressed(bits);
        if (k != cand_key) begin
            cand_key = k;
            cand_since_ms = now;
        end

        since = now - cand_since_ms;
        if (since >= msec_t'(debounce_time) && steady_key != cand_key) begin
            prev = steady_key;
            steady_key = cand_key;
            if (steady_key != KEY_NONE) begin
                held_since_ms = now;
                long_sent = 1'b0;
                // star waits for its release or for the long hold
                if (steady_key != KEY_STAR)
                    return steady_key;
            end else if (prev == KEY_STAR && !long_sent) begin
                return KEY_STAR;
            end
        end

        since = now - held_since_ms;
        if (steady_key == KEY_STAR && !long_sent && since >= msec_t'(long_time)) begin
            long_sent = 1'b1;
            return KEY_LONG;
        end
        return KEY_NONE;
    endfunction

    always @(posedge aclk) begin
        key_t want;
        if (!aresetn) begin
            scan_period   = SCAN_PERIOD_RST;
            debounce_time = DEBOUNCE_RST;
            long_time     = LONG_PRESS_RST;
            prev_scan_ms  = '0;
            cand_since_ms = '0;
            held_since_ms = '0;
            cand_key      = KEY_NONE;
            steady_key    = KEY_NONE;
            long_sent     = 1'b0;
            events_due.delete();
            n_fail    <= 0;
            n_results <= 0;
            n_due     <= 0;
            n_events  <= 0;
            n_long    <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SCAN_PERIOD: scan_period   = cfg_wr_data[7:0];
                    CFG_DEBOUNCE:    debounce_time = cfg_wr_data;
                    CFG_LONG_PRESS:  long_time     = cfg_wr_data;
                    default: ;
                endcase
            end

            // retire before predicting: a sample never leaves in the cycle it enters
            if (m_tvalid && m_tready) begin
                n_results <= n_results + 1;
                if (events_due.size() == 0) begin
                    if (n_fail < 10)
                        $display("%0t: key event %h arrived with nothing pending",
                                 $realtime, m_tdata);
                    n_fail <= n_fail + 1;
                end else begin
                    want = events_due.pop_front();
                    if (m_tdata !== {1'b0, want}) begin
                        if (n_fail < 10)
                            $display("%0t: key event mismatch, expected %h got %h",
                                     $realtime, {1'b0, want}, m_tdata);
                        n_fail <= n_fail + 1;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                want = scan_sample(s_tdata[31:0], s_tdata[43:32]);
                events_due.push_back(want);
                if (want != KEY_NONE) n_events <= n_events + 1;
                if (want == KEY_LONG) n_long <= n_long + 1;
            end

            n_due <= events_due.size();
        end
    end

endmodule

// File: test/tb_keypad_debounce_long_press.sv
// ----------------------------------------------------------------------------
// Keypad debouncer testbench
// Drives time-stamped keypad samples through the block under several register
// settings and idling patterns; a separate checker predicts every key event.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_keypad_debounce_long_press;
    import kdlp_pkg::*;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    localparam cfg_addr_t CFG_UNUSED      = 2'd3;
    localparam int        HOLD_OFF_CYCLES = 300;
    localparam int        WATCHDOG_LIMIT  = 4000;
    localparam int        N_PHASES        = 9;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;      // [31:0] time_now, [43:32] key_matrix
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;               // [6:0] key_event
    logic        cfg_wr_en   = 1'b0;
    cfg_addr_t   cfg_addr    = CFG_SCAN_PERIOD;
    logic [15:0] cfg_wr_data = '0;

    idle_mode_t idle_mode = IDLE_NONE;
    logic       hold_req  = 1'b0;
    logic       hold_ack  = 1'b0;
    int         hold_left = 0;
    int         idle_cycles = 0;

    int    n_fail, n_results, n_due, n_events, n_long;
    int    sent_count = 0;
    msec_t tnow = '0;
    int    scan_ms, deb_ms, lp_ms;

    always #1 aclk = ~aclk;

    keypad_debounce_long_press DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    keypad_event_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .n_fail      (n_fail),
        .n_results   (n_results),
        .n_due       (n_due),
        .n_events    (n_events),
        .n_long      (n_long)
    );

    // Event sink: random stalls per mode, plus one long hold-off on request
    always @(posedge aclk) begin
        int stall_pct;
        stall_pct = (idle_mode == IDLE_SINK) ? 67 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_keypad_debounce_long_press: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input msec_t t, input matrix_t m);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SRC) ? 67 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, m, t};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Stop offering and wait until every sample's event has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (n_results < sent_count) @(posedge aclk);
    endtask

    // The scan period word carries junk in its upper byte, which must be dropped
    task automatic program_regs(input logic [15:0] sp_word, input logic [15:0] db,
                                input logic [15:0] lp);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_UNUSED;
        cfg_wr_data <= 16'($urandom);
        @(posedge aclk);
        cfg_addr    <= CFG_SCAN_PERIOD;
        cfg_wr_data <= sp_word;
        @(posedge aclk);
        cfg_addr    <= CFG_DEBOUNCE;
        cfg_wr_data <= db;
        @(posedge aclk);
        cfg_addr    <= CFG_LONG_PRESS;
        cfg_wr_data <= lp;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scan_ms = int'(sp_word[7:0]);
        deb_ms  = int'(db);
        lp_ms   = int'(lp);
    endtask

    // Key holds of random length: bounces shorter than the debounce time,
    // ordinary presses, and holds long enough for the star long press
    task automatic run_phase(input int n_items, input bit with_hold);
        int      done_items, nseg, hold, step, pos, r;
        matrix_t held;
        done_items = 0;
        while (done_items < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 3)      tnow = $urandom();
            else if (r < 6) tnow = 32'hFFFF_FFFF - $urandom_range(0, 400);

            r = $urandom_range(0, 99);
            if (r < 20) begin
                held = '0;
            end else begin
                pos  = (r < 45) ? 9 : $urandom_range(0, 11);
                held = matrix_t'($urandom) & ~((matrix_t'(1) << (pos + 1)) - 1);
                held = held | (matrix_t'(1) << pos);
            end

            r = $urandom_range(0, 99);
            if (r < 30)      hold = $urandom_range(0, deb_ms);
            else if (r < 70) hold = deb_ms + $urandom_range(0, lp_ms);
            else             hold = deb_ms + lp_ms + $urandom_range(0, 20);
            nseg = $urandom_range(1, 6);
            step = (hold + nseg - 1) / nseg;
            if (step < scan_ms) step = scan_ms;
            step = step + $urandom_range(0, 1);

            for (int k = 0; k <= nseg; k++) begin
                if ($urandom_range(0, 99) < 8)
                    send_item(tnow + $urandom_range(0, scan_ms), matrix_t'($urandom));
                tnow = tnow + step;
                send_item(tnow, ($urandom_range(0, 99) < 6) ? matrix_t'($urandom) : held);
                done_items++;
                if (with_hold && done_items == 60)
                    hold_req <= ~hold_req;
            end
        end
    endtask

    initial begin
        logic [7:0]  r_sp;
        logic [15:0] r_db, r_lp;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: fast settings so each case shows in a step or two
        program_regs(16'hA501, 16'd0, 16'd3);
        send_item(32'd10, 12'h000);
        send_item(32'd11, 12'h001);
        send_item(32'd11, 12'h002);      // too soon, skipped
        send_item(32'd12, 12'h006);      // direct change to another key
        send_item(32'd13, 12'h200);      // star stable, silent
        send_item(32'd14, 12'h000);      // short star on release
        send_item(32'd15, 12'hE00);
        send_item(32'd18, 12'h200);      // long press
        send_item(32'd19, 12'h000);      // release after long press is silent
        send_item(32'd20, 12'h800);
        send_item(32'd21, 12'h400);
        send_item(32'd22, 12'hFFF);
        send_item(32'd23, 12'h100);
        send_item(32'd24, 12'h080);
        send_item(32'd25, 12'h000);
        send_item(32'hFFFF_FFFF, 12'h004);
        send_item(32'h0000_0000, 12'h008);   // wraps across zero
        drain();
        program_regs(16'h0000, 16'd0, 16'd0);
        send_item(32'd0, 12'h200);       // star stable and long press at once
        send_item(32'd0, 12'h010);
        send_item(32'd0, 12'h020);
        send_item(32'd1, 12'h040);
        tnow = 32'd100;

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            case (p)
                0: program_regs(16'h3C01, 16'd0, 16'd0);
                1: program_regs(16'h00FF, 16'hFFFF, 16'hFFFF);
                2: program_regs(16'h7700, 16'd3, 16'd10);
                3: program_regs({8'h00, SCAN_PERIOD_RST}, DEBOUNCE_RST, LONG_PRESS_RST);
                default: begin
                    r_sp = 8'(($urandom_range(0, 99) < 70) ? $urandom_range(1, 10)
                                                           : $urandom_range(1, 255));
                    r_db = 16'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 50)
                                                            : $urandom_range(0, 65535));
                    r_lp = 16'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 300)
                                                            : $urandom_range(0, 65535));
                    program_regs({8'($urandom), r_sp}, r_db, r_lp);
                end
            endcase
            idle_mode <= idle_mode_t'(p % 4);
            run_phase(185, p == 4 || p == 7);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("covered %0d samples over %0d register settings with all idling patterns",
                 sent_count, N_PHASES + 2);
        $display("checked %0d events, %0d key reports of which %0d long presses",
                 n_results, n_events, n_long);
        if (n_fail == 0 && n_due == 0)
            $display("tb_keypad_debounce_long_press: clean");
        else
            $display("tb_keypad_debounce_long_press: errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/kdlp_pkg.sv
src/kdlp_engine.sv
src/keypad_debounce_long_press.sv
test/keypad_event_checker.sv
test/tb_keypad_debounce_long_press.sv
